@@ rtl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg: shared types for the barometric sensor compensation block
// Payload structs, register indexes and fixed compensation constants.
// ----------------------------------------------------------------------------
package bsc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } bsc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_decidegrees;
    logic [17:0]        pressure_pa;
    logic               divide_fault;
  } bsc_out_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
    logic               pen;
  } bsc_cal_t;

  localparam logic [2:0] RegAc1Ac2 = 3'd0;
  localparam logic [2:0] RegAc3Ac4 = 3'd1;
  localparam logic [2:0] RegAc5Ac6 = 3'd2;
  localparam logic [2:0] RegB1B2   = 3'd3;
  localparam logic [2:0] RegMcMd   = 3'd4;
  localparam logic [2:0] RegOss    = 3'd5;
  localparam logic [2:0] RegPen    = 3'd6;

  localparam int unsigned PMax = 262143;

endpackage

@@ rtl/bsc_div.sv @@
// ----------------------------------------------------------------------------
// bsc_div: pipelined restoring divider
// One quotient bit per stage; carries a side payload alongside.
// ----------------------------------------------------------------------------
module bsc_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  logic                 v_q [NW];
  logic [NW-1:0]        n_q [NW];
  logic [DW-1:0]        d_q [NW];
  logic [DW:0]          r_q [NW];
  logic [SW-1:0]        s_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          v_in;
    logic [NW-1:0] n_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   r_in;
    logic [SW-1:0] s_in;
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    if (k == 0) begin : g_head
      assign v_in = valid_i;
      assign n_in = num_i;
      assign d_in = den_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_link
      assign v_in = v_q[k-1];
      assign n_in = n_q[k-1];
      assign d_in = d_q[k-1];
      assign r_in = r_q[k-1];
      assign s_in = s_q[k-1];
    end
    assign sh = {r_in, n_in[NW-1]};
    assign df = sh - {2'b0, d_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      d_q[k] <= d_in;
      s_q[k] <= s_in;
      if (!df[DW+1]) begin
        r_q[k] <= df[DW:0];
        n_q[k] <= {n_in[NW-2:0], 1'b1};
      end else begin
        r_q[k] <= sh[DW:0];
        n_q[k] <= {n_in[NW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = n_q[NW-1];
  assign side_o  = s_q[NW-1];
endmodule

@@ rtl/bsc_cfg.sv @@
// ----------------------------------------------------------------------------
// bsc_cfg: calibration register file
// Holds the coefficients, oversampling setting and pressure enable.
// ----------------------------------------------------------------------------
module bsc_cfg import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output bsc_cal_t    cal_o
);
  bsc_cal_t cal_q, cal_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cal_d = cal_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegAc1Ac2: begin cal_d.ac1 = cfg_data_i[31:16]; cal_d.ac2 = cfg_data_i[15:0]; end
        RegAc3Ac4: begin cal_d.ac3 = cfg_data_i[31:16]; cal_d.ac4 = cfg_data_i[15:0]; end
        RegAc5Ac6: begin cal_d.ac5 = cfg_data_i[31:16]; cal_d.ac6 = cfg_data_i[15:0]; end
        RegB1B2:   begin cal_d.b1  = cfg_data_i[31:16]; cal_d.b2  = cfg_data_i[15:0]; end
        RegMcMd:   begin cal_d.mc  = cfg_data_i[31:16]; cal_d.md  = cfg_data_i[15:0]; end
        RegOss:    cal_d.oss = cfg_data_i[1:0];
        RegPen:    cal_d.pen = cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '{pen: 1'b1, default: '0};
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;
endmodule

@@ rtl/baro_sensor_compensation_top.sv @@
// ----------------------------------------------------------------------------
// baro_sensor_compensation_top: integer temperature and pressure compensation
// The pipeline accepts one item per cycle.
// The depth is set by two bit-serial pipelined dividers (temperature: 27
// stages, pressure: 33 stages) plus 15 register stages around them.
// busy is always low: the pipeline never stalls, results cannot be held.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_top import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  bsc_in_t     in_i,
  output logic        done_o,
  output bsc_out_t    out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  bsc_cal_t cal;

  bsc_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cal_o(cal)
  );

  assign busy = 1'b0;

  // ---------------- temperature front: x1 = ((ut-ac6)*ac5)>>>15
  logic               v1_q;
  logic [18:0]        up1_q;
  logic signed [16:0] d1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    up1_q <= in_i.raw_pressure;
    d1_q  <= $signed({1'b0, in_i.raw_temperature}) - $signed({1'b0, cal.ac6});
  end

  logic               v2_q;
  logic [18:0]        up2_q;
  logic signed [33:0] m2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    up2_q <= up1_q;
    m2_q  <= d1_q * $signed({1'b0, cal.ac5});
  end

  // x1 is within 19 signed bits; den within 20
  logic signed [18:0] x1_t;
  logic signed [19:0] den_t;
  assign x1_t  = 19'(m2_q >>> 15);
  assign den_t = 20'(x1_t) + 20'(cal.md);

  logic               v3_q;
  logic [18:0]        up3_q;
  logic signed [18:0] x13_q;
  logic               tz3_q;
  logic               qneg3_q;
  logic [26:0]        num3_q;
  logic [19:0]        dmag3_q;
  logic signed [27:0] mcs;
  assign mcs = 28'(cal.mc) <<< 11;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    up3_q   <= up2_q;
    x13_q   <= x1_t;
    tz3_q   <= (den_t == '0);
    qneg3_q <= mcs[27] ^ den_t[19];
    num3_q  <= 27'(mcs[27] ? -mcs : mcs);
    dmag3_q <= 20'(den_t[19] ? -den_t : den_t);
  end

  localparam int unsigned TSW = 19 + 19 + 2;
  logic           vt_o;
  logic [26:0]    qt;
  logic [TSW-1:0] st;
  bsc_div #(.NW(27), .DW(20), .SW(TSW)) u_tdiv (
    .clk_i, .rst_ni, .valid_i(v3_q), .num_i(num3_q), .den_i(dmag3_q),
    .side_i({up3_q, x13_q, tz3_q, qneg3_q}),
    .valid_o(vt_o), .quo_o(qt), .side_o(st)
  );

  // ---------------- b5 and temperature
  logic signed [18:0] x1d;
  logic [18:0]        upd;
  logic               tzd, qnd;
  assign {upd, x1d, tzd, qnd} = st;

  logic signed [27:0] x2s;
  assign x2s = qnd ? -$signed({1'b0, qt}) : $signed({1'b0, qt});

  logic               v4_q, tz4_q;
  logic [18:0]        up4_q;
  logic signed [28:0] b54_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= vt_o;
  end
  always_ff @(posedge clk_i) begin
    up4_q <= upd;
    tz4_q <= tzd;
    b54_q <= 29'(x1d) + 29'(x2s);
  end

  logic signed [24:0] tr;
  logic signed [15:0] tsat;
  assign tr = 25'((b54_q + 29'sd8) >>> 4);
  always_comb begin
    if (tr > 25'sd32767)       tsat = 16'sh7fff;
    else if (tr < -25'sd32768) tsat = 16'sh8000;
    else                       tsat = 16'(tr);
  end

  // b6 and b6^2
  logic               v5_q, tz5_q;
  logic [18:0]        up5_q;
  logic signed [15:0] t5_q;
  logic signed [29:0] b65_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    up5_q <= up4_q;
    tz5_q <= tz4_q;
    t5_q  <= tsat;
    b65_q <= 30'(b54_q) - 30'sd4000;
  end

  // b6 magnitude under 2^29; square in 2 partial products of 29x15 and 29x14
  logic [28:0] b6m;
  assign b6m = 29'(b65_q[29] ? -b65_q : b65_q);

  logic               v6_q, tz6_q;
  logic [18:0]        up6_q;
  logic signed [15:0] t6_q;
  logic signed [29:0] b66_q;
  logic [43:0]        pl6_q, ph6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    up6_q <= up5_q; tz6_q <= tz5_q; t6_q <= t5_q; b66_q <= b65_q;
    pl6_q <= 44'(b6m) * 44'(b6m[14:0]);
    ph6_q <= 44'(b6m) * 44'(b6m[28:15]);
  end

  // sq = b6^2 >> 12, up to 46 bits; kept positive
  logic               v7_q, tz7_q;
  logic [18:0]        up7_q;
  logic signed [15:0] t7_q;
  logic signed [29:0] b67_q;
  logic [45:0]        sq7_q;
  logic [58:0]        sqf;
  assign sqf = 59'(pl6_q) + (59'(ph6_q) << 15);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else         v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    up7_q <= up6_q; tz7_q <= tz6_q; t7_q <= t6_q; b67_q <= b66_q;
    sq7_q <= 46'(sqf >> 12);
  end

  // products with coefficients: b2*sq, b1*sq (split sq in halves), ac2*b6, ac3*b6
  logic               v8_q, tz8_q;
  logic [18:0]        up8_q;
  logic signed [15:0] t8_q;
  logic signed [40:0] b2l_q, b1l_q, b2h_q, b1h_q;
  logic signed [46:0] a2_q, a3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else         v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    up8_q <= up7_q; tz8_q <= tz7_q; t8_q <= t7_q;
    b2l_q <= 41'(cal.b2) * $signed({1'b0, sq7_q[22:0]});
    b2h_q <= 41'(cal.b2) * $signed({1'b0, sq7_q[45:23]});
    b1l_q <= 41'(cal.b1) * $signed({1'b0, sq7_q[22:0]});
    b1h_q <= 41'(cal.b1) * $signed({1'b0, sq7_q[45:23]});
    a2_q  <= 47'(cal.ac2) * 47'(b67_q);
    a3_q  <= 47'(cal.ac3) * 47'(b67_q);
  end

  logic signed [63:0] b2sq, b1sq;
  assign b2sq = 64'(b2l_q) + (64'(b2h_q) <<< 23);
  assign b1sq = 64'(b1l_q) + (64'(b1h_q) <<< 23);

  logic               v9_q, tz9_q;
  logic [18:0]        up9_q;
  logic signed [15:0] t9_q;
  logic signed [63:0] x3b_q, x3c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else         v9_q <= v8_q;
  end
  always_ff @(posedge clk_i) begin
    up9_q <= up8_q; tz9_q <= tz8_q; t9_q <= t8_q;
    x3b_q <= (b2sq >>> 11) + (64'(a2_q) >>> 11);
    x3c_q <= (((64'(a3_q) >>> 13) + (b1sq >>> 16) + 64'sd2) >>> 2);
  end

  // b3 and b4 (b4 via 16x32 product, mod 2^32)
  logic signed [63:0] b3;
  logic [31:0]        x3u;
  assign b3  = ((((64'(cal.ac1) <<< 2) + x3b_q) <<< cal.oss) + 64'sd2) >>> 2;
  assign x3u = 32'(x3c_q + 64'sd32768);

  logic               v10_q, tz10_q;
  logic [18:0]        up10_q;
  logic signed [15:0] t10_q;
  logic [31:0]        b3_q;
  logic [47:0]        b4p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v10_q <= 1'b0;
    else         v10_q <= v9_q;
  end
  always_ff @(posedge clk_i) begin
    up10_q <= up9_q; tz10_q <= tz9_q; t10_q <= t9_q;
    b3_q   <= 32'(b3);
    b4p_q  <= 48'(cal.ac4) * 48'(x3u);
  end

  logic [31:0] b4;
  logic [31:0] dup;
  logic [15:0] kc;
  assign b4  = 32'(b4p_q[31:0] >> 15);
  assign dup = 32'({13'b0, up10_q}) - b3_q;
  assign kc  = 16'(50000 >> cal.oss);

  logic               v11_q, tz11_q, pz11_q;
  logic signed [15:0] t11_q;
  logic [31:0]        b411_q;
  logic [47:0]        b7p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v11_q <= 1'b0;
    else         v11_q <= v10_q;
  end
  always_ff @(posedge clk_i) begin
    tz11_q <= tz10_q; t11_q <= t10_q;
    pz11_q <= (b4 == '0);
    b411_q <= b4;
    b7p_q  <= 48'(dup) * 48'(kc);
  end

  // b7 < 2^31: p = 2*b7/b4, else p = 2*(b7/b4); one 33-bit divide covers both
  logic [31:0] b7;
  logic [32:0] pnum;
  logic        hi7;
  assign b7   = b7p_q[31:0];
  assign hi7  = b7[31];
  assign pnum = hi7 ? {1'b0, b7} : {b7, 1'b0};

  localparam int unsigned PSW = 16 + 3;
  logic           vp_o;
  logic [32:0]    qp;
  logic [PSW-1:0] sp;
  bsc_div #(.NW(33), .DW(32), .SW(PSW)) u_pdiv (
    .clk_i, .rst_ni, .valid_i(v11_q), .num_i(pnum),
    .den_i(pz11_q ? 32'd1 : b411_q),
    .side_i({t11_q, tz11_q, pz11_q, hi7}),
    .valid_o(vp_o), .quo_o(qp), .side_o(sp)
  );

  logic signed [15:0] tp;
  logic               tzp, pzp, hip;
  assign {tp, tzp, pzp, hip} = sp;

  logic               v12_q, tz12_q, pz12_q;
  logic signed [15:0] t12_q;
  logic [33:0]        p12_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v12_q <= 1'b0;
    else         v12_q <= vp_o;
  end
  always_ff @(posedge clk_i) begin
    tz12_q <= tzp; pz12_q <= pzp; t12_q <= tp;
    p12_q  <= hip ? {qp, 1'b0} : {1'b0, qp};
  end

  // p >> 8 < 2^26; square split into two 26x13 products
  logic [25:0] ph;
  assign ph = p12_q[33:8];

  logic               v13_q, tz13_q, pz13_q;
  logic signed [15:0] t13_q;
  logic [33:0]        p13_q;
  logic [38:0]        sl13_q, sh13_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v13_q <= 1'b0;
    else         v13_q <= v12_q;
  end
  always_ff @(posedge clk_i) begin
    tz13_q <= tz12_q; pz13_q <= pz12_q; t13_q <= t12_q; p13_q <= p12_q;
    sl13_q <= 39'(ph) * 39'(ph[12:0]);
    sh13_q <= 39'(ph) * 39'(ph[25:13]);
  end

  logic [51:0] psq;
  assign psq = 52'(sl13_q) + (52'(sh13_q) << 13);

  // x1 = (psq*3038)>>16: psq*3038 split; x2 = (-7357*p)>>16
  logic               v14_q, tz14_q, pz14_q;
  logic signed [15:0] t14_q;
  logic [33:0]        p14_q;
  logic [37:0]        xl14_q;
  logic [37:0]        xh14_q;
  logic signed [49:0] x214_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v14_q <= 1'b0;
    else         v14_q <= v13_q;
  end
  always_ff @(posedge clk_i) begin
    tz14_q <= tz13_q; pz14_q <= pz13_q; t14_q <= t13_q; p14_q <= p13_q;
    xl14_q <= 38'(psq[25:0]) * 38'd3038;
    xh14_q <= 38'(psq[51:26]) * 38'd3038;
    x214_q <= -50'sd7357 * $signed({16'b0, p13_q});
  end

  logic [69:0] x1f;
  logic signed [71:0] corr;
  logic signed [71:0] pf;
  assign x1f  = 70'(xl14_q) + (70'(xh14_q) << 26);
  assign corr = ($signed({2'b0, x1f >> 16}) + (72'(x214_q) >>> 16) + 72'sd3791) >>> 4;
  assign pf   = $signed({38'b0, p14_q}) + corr;

  logic               v15_q;
  bsc_out_t           o15_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v15_q <= 1'b0;
    else         v15_q <= v14_q;
  end
  always_ff @(posedge clk_i) begin
    if (tz14_q) begin
      o15_q <= '{temperature_decidegrees: '0, pressure_pa: '0, divide_fault: 1'b1};
    end else if (!cal.pen) begin
      o15_q <= '{temperature_decidegrees: t14_q, pressure_pa: '0, divide_fault: 1'b0};
    end else if (pz14_q) begin
      o15_q <= '{temperature_decidegrees: t14_q, pressure_pa: '0, divide_fault: 1'b1};
    end else begin
      o15_q.temperature_decidegrees <= t14_q;
      o15_q.divide_fault <= 1'b0;
      if (pf < 0)                 o15_q.pressure_pa <= '0;
      else if (pf > 72'(PMax))    o15_q.pressure_pa <= 18'(PMax);
      else                        o15_q.pressure_pa <= 18'(pf);
    end
  end

  assign done_o = v15_q;
  assign out_o  = o15_q;
endmodule
